// ===== design/snx_pkg.sv =====
`timescale 1ns / 1ps

package snx_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int POS_W         = 32;
    localparam int NOISE_W       = 18;
    localparam int K_FRAC        = 30;
    localparam int OUT_FRAC      = 16;
    localparam int NOISE_GAIN    = 70;
    localparam int OUT_LIMIT     = 65536;

    // skew and unskew factors with K_FRAC fractional bits
    localparam logic signed [31:0] F2_K = 32'sd393016785;
    localparam logic signed [31:0] G2_K = 32'sd226908346;

    localparam logic [7:0] PERM_TAB [256] = '{
        8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
        8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
        8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
        8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
        8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
        8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
        8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
        8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
        8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
        8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
        8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
        8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
        8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
        8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
        8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
        8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
        8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
        8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
        8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
        8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
        8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
        8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
        8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
        8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
        8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
        8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
        8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
        8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
        8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
        8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
        8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
        8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
    };

    // per-stage load enables of the corner pipeline
    typedef struct packed {
        logic sq;
        logic rk;
        logic a1;
        logic a2;
        logic mul;
    } snx_cen_t;

    // gradient as enable and negate per axis
    typedef struct packed {
        logic x_en;
        logic x_neg;
        logic y_en;
        logic y_neg;
    } snx_grad_t;

    function automatic logic [7:0] snx_perm(input logic [7:0] k);
        return PERM_TAB[k];
    endfunction

    // v mod 12 via reciprocal multiply, exact for 8-bit v
    function automatic logic [3:0] snx_mod12(input logic [7:0] v);
        logic [15:0] p;
        logic [4:0]  q;
        logic [7:0]  r;
        p = {8'd0, v} * 16'd171;
        q = p[15:11];
        r = v - ({3'd0, q} * 8'd12);
        return r[3:0];
    endfunction

    function automatic snx_grad_t snx_grad(input logic [3:0] idx);
        snx_grad_t g;
        case (idx)
            4'd0:    g = '{x_en: 1'b1, x_neg: 1'b0, y_en: 1'b1, y_neg: 1'b0};
            4'd1:    g = '{x_en: 1'b1, x_neg: 1'b1, y_en: 1'b1, y_neg: 1'b0};
            4'd2:    g = '{x_en: 1'b1, x_neg: 1'b0, y_en: 1'b1, y_neg: 1'b1};
            4'd3:    g = '{x_en: 1'b1, x_neg: 1'b1, y_en: 1'b1, y_neg: 1'b1};
            4'd4:    g = '{x_en: 1'b1, x_neg: 1'b0, y_en: 1'b0, y_neg: 1'b0};
            4'd5:    g = '{x_en: 1'b1, x_neg: 1'b1, y_en: 1'b0, y_neg: 1'b0};
            4'd6:    g = '{x_en: 1'b1, x_neg: 1'b0, y_en: 1'b0, y_neg: 1'b0};
            4'd7:    g = '{x_en: 1'b1, x_neg: 1'b1, y_en: 1'b0, y_neg: 1'b0};
            4'd8:    g = '{x_en: 1'b0, x_neg: 1'b0, y_en: 1'b1, y_neg: 1'b0};
            4'd9:    g = '{x_en: 1'b0, x_neg: 1'b0, y_en: 1'b1, y_neg: 1'b1};
            4'd10:   g = '{x_en: 1'b0, x_neg: 1'b0, y_en: 1'b1, y_neg: 1'b0};
            4'd11:   g = '{x_en: 1'b0, x_neg: 1'b0, y_en: 1'b1, y_neg: 1'b1};
            default: g = '{x_en: 1'b0, x_neg: 1'b0, y_en: 1'b0, y_neg: 1'b0};
        endcase
        return g;
    endfunction

endpackage

// ===== design/simplex_noise_2d.sv =====
`timescale 1ns / 1ps
// throughput: one item per cycle while out_stall stays low; each of the 13 stages holds one item
// the ready chain is combinational, so bubbles are squeezed out before in_stall rises
// reset: asynchronous active-low rst_n clears all stage valid bits; payload is not reset

module simplex_noise_2d
    import snx_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [POS_W-1:0]   x_pos,
    input  logic signed [POS_W-1:0]   y_pos,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [NOISE_W-1:0] noise_value
);

    localparam int NSTG = 13;
    // corner offsets stay within a few units, so a narrow coordinate suffices
    localparam int CW   = FRAC_BITS + 4;
    localparam int SPW  = 63;
    localparam int SW   = 34;
    localparam int IW   = 35 - FRAC_BITS;
    localparam int TPW  = IW + 30;
    localparam int XRW  = 36;
    localparam int CPW  = K_FRAC + 6;
    localparam int SMW  = CPW + 2;
    localparam int GPW  = SMW + 7;
    localparam int G_INT =
        (226908346 + (1 << (K_FRAC - FRAC_BITS - 1))) >> (K_FRAC - FRAC_BITS);
    localparam logic signed [CW-1:0]  ONE_C = CW'(1) << FRAC_BITS;
    localparam logic signed [CW-1:0]  G_C   = CW'(G_INT);
    localparam logic signed [GPW-1:0] LIM_P = GPW'(OUT_LIMIT);
    localparam logic signed [GPW-1:0] LIM_N = -LIM_P;

    // valid bit per stage and the ready chain
    logic [NSTG-1:0] v_reg, v_next;
    logic [NSTG-1:0] rdy;

    always_comb
    begin
        rdy[NSTG-1] = !v_reg[NSTG-1] || !out_stall;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
        for (int k = 0; k < NSTG; k++)
        begin
            if (rdy[k])
            begin
                v_next[k] = (k == 0) ? in_valid : v_reg[(k == 0) ? 0 : k - 1];
            end
            else
            begin
                v_next[k] = v_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign in_stall  = !rdy[0];
    assign out_valid = v_reg[NSTG-1];

    // stage 1: skew product (x + y) * F2
    logic signed [POS_W-1:0] x1_reg, y1_reg;
    logic signed [SPW-1:0]   sp1_reg, sp1_next;
    logic signed [POS_W:0]   sum_xy;

    // stage 2: cell indices i = floor(x + s), j = floor(y + s)
    logic signed [POS_W-1:0] x2_reg, y2_reg;
    logic signed [IW-1:0]    i2_reg, i2_next, j2_reg, j2_next;
    logic signed [SW-1:0]    s_val;
    logic signed [SW:0]      xs, ys;

    // stage 3: unskew product and coordinate minus cell origin
    logic signed [TPW-1:0]   tp3_reg, tp3_next;
    logic signed [XRW-1:0]   xr3_reg, xr3_next, yr3_reg, yr3_next;
    logic [7:0]              ii3_reg, jj3_reg;
    logic signed [IW:0]      ij;

    // stage 4: first corner offset, row hashes for j and j + 1
    logic signed [CW-1:0]    x0_4_reg, x0_4_next, y0_4_reg, y0_4_next;
    logic [7:0]              ii4_reg, jj4_reg, pj4_reg, pj4_next, pj14_reg, pj14_next;
    logic signed [XRW-1:0]   t_val;

    // stage 5: triangle choice, other corners, outer hashes of corners 0 and 2
    logic signed [CW-1:0]    c5_reg [6];
    logic signed [CW-1:0]    c5_next [6];
    logic                    i1_5_reg, i1_5_next;
    logic [7:0]              ii5_reg, pm5_reg, pm5_next, h0_5_reg, h0_5_next;
    logic [7:0]              h2_5_reg, h2_5_next;

    // stage 6: middle corner hash, gradient indices
    logic signed [CW-1:0]    c6_reg [6];
    logic [3:0]              g6_reg [3];
    logic [3:0]              g6_next [3];
    logic [7:0]              h1;

    // stages 7 to 11: corner contributions; stage 12 sum; stage 13 gain and clamp
    snx_cen_t                cen;
    logic signed [CPW-1:0]   contrib [3];
    logic signed [SMW-1:0]   sum12_reg, sum12_next;
    logic signed [GPW-1:0]   gp, n_sh;
    logic signed [NOISE_W-1:0] out_reg, out_next;

    always_comb
    begin
        sum_xy   = {x_pos[POS_W-1], x_pos} + {y_pos[POS_W-1], y_pos};
        sp1_next = sum_xy * F2_K;

        s_val   = SW'(sp1_reg >>> K_FRAC);
        xs      = (SW+1)'(x1_reg) + (SW+1)'(s_val);
        ys      = (SW+1)'(y1_reg) + (SW+1)'(s_val);
        i2_next = IW'(xs >>> FRAC_BITS);
        j2_next = IW'(ys >>> FRAC_BITS);

        ij       = (IW+1)'(i2_reg) + (IW+1)'(j2_reg);
        tp3_next = ij * G2_K;
        xr3_next = XRW'(x2_reg) - (XRW'(i2_reg) <<< FRAC_BITS);
        yr3_next = XRW'(y2_reg) - (XRW'(j2_reg) <<< FRAC_BITS);

        t_val     = XRW'(tp3_reg >>> (K_FRAC - FRAC_BITS));
        x0_4_next = CW'(xr3_reg + t_val);
        y0_4_next = CW'(yr3_reg + t_val);
        pj4_next  = snx_perm(jj3_reg);
        pj14_next = snx_perm(jj3_reg + 8'd1);

        // lower triangle only when x0 > y0 strictly
        i1_5_next  = (x0_4_reg > y0_4_reg);
        c5_next[0] = x0_4_reg;
        c5_next[1] = y0_4_reg;
        c5_next[2] = x0_4_reg - (i1_5_next ? ONE_C : '0) + G_C;
        c5_next[3] = y0_4_reg - (i1_5_next ? '0 : ONE_C) + G_C;
        c5_next[4] = x0_4_reg - ONE_C + (G_C <<< 1);
        c5_next[5] = y0_4_reg - ONE_C + (G_C <<< 1);
        pm5_next   = snx_perm(jj4_reg + {7'd0, !i1_5_next});
        h0_5_next  = snx_perm(ii4_reg + pj4_reg);
        h2_5_next  = snx_perm(ii4_reg + 8'd1 + pj14_reg);

        h1         = snx_perm(ii5_reg + {7'd0, i1_5_reg} + pm5_reg);
        g6_next[0] = snx_mod12(h0_5_reg);
        g6_next[1] = snx_mod12(h1);
        g6_next[2] = snx_mod12(h2_5_reg);

        sum12_next = SMW'(contrib[0]) + SMW'(contrib[1]) + SMW'(contrib[2]);

        gp   = GPW'(sum12_reg) * GPW'(NOISE_GAIN);
        n_sh = gp >>> (K_FRAC - OUT_FRAC);
        if (n_sh > LIM_P)
        begin
            out_next = NOISE_W'(LIM_P);
        end
        else if (n_sh < LIM_N)
        begin
            out_next = NOISE_W'(LIM_N);
        end
        else
        begin
            out_next = NOISE_W'(n_sh);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            x1_reg  <= x_pos;
            y1_reg  <= y_pos;
            sp1_reg <= sp1_next;
        end
        if (rdy[1])
        begin
            x2_reg <= x1_reg;
            y2_reg <= y1_reg;
            i2_reg <= i2_next;
            j2_reg <= j2_next;
        end
        if (rdy[2])
        begin
            tp3_reg <= tp3_next;
            xr3_reg <= xr3_next;
            yr3_reg <= yr3_next;
            ii3_reg <= i2_reg[7:0];
            jj3_reg <= j2_reg[7:0];
        end
        if (rdy[3])
        begin
            x0_4_reg <= x0_4_next;
            y0_4_reg <= y0_4_next;
            ii4_reg  <= ii3_reg;
            jj4_reg  <= jj3_reg;
            pj4_reg  <= pj4_next;
            pj14_reg <= pj14_next;
        end
        if (rdy[4])
        begin
            c5_reg   <= c5_next;
            i1_5_reg <= i1_5_next;
            ii5_reg  <= ii4_reg;
            pm5_reg  <= pm5_next;
            h0_5_reg <= h0_5_next;
            h2_5_reg <= h2_5_next;
        end
        if (rdy[5])
        begin
            c6_reg <= c5_reg;
            g6_reg <= g6_next;
        end
        if (rdy[11])
        begin
            sum12_reg <= sum12_next;
        end
        if (rdy[12])
        begin
            out_reg <= out_next;
        end
    end

    assign cen = '{sq: rdy[6], rk: rdy[7], a1: rdy[8], a2: rdy[9], mul: rdy[10]};

    for (genvar c = 0; c < 3; c++)
    begin : g_corner
        snx_corner #(
            .FRAC_BITS (FRAC_BITS)
        ) u_corner (
            .clk     (clk),
            .en      (cen),
            .cx      (c6_reg[2*c]),
            .cy      (c6_reg[2*c+1]),
            .gidx    (g6_reg[c]),
            .contrib (contrib[c])
        );
    end

    assign noise_value = out_reg;

    // result never leaves the saturation range
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (noise_value <= 18'sd65536) && (noise_value >= -18'sd65536))
        else $error("noise_value out of range");

    // input is held back only when every stage is full and the output waits
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall && (&v_reg)))
        else $error("input stalled with room in the pipeline");

    // an item just behind the output moves up when the output drains
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && v_reg[NSTG-2]) |=> out_valid)
        else $error("item lost behind output stage");

endmodule

// ===== design/snx_corner.sv =====
`timescale 1ns / 1ps

module snx_corner
    import snx_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                        clk,
    input  snx_cen_t                    en,
    input  logic signed [FRAC_BITS+3:0] cx,
    input  logic signed [FRAC_BITS+3:0] cy,
    input  logic [3:0]                  gidx,
    output logic signed [K_FRAC+5:0]    contrib
);

    localparam int CW  = FRAC_BITS + 4;
    localparam int SQW = 2 * CW;
    localparam int RW  = 2 * CW + 2;
    localparam int DW  = CW + 1;
    localparam int AW  = K_FRAC;
    localparam int PW  = AW + 1 + DW;
    localparam int CPW = PW - FRAC_BITS;
    localparam logic signed [RW-1:0] HALF = RW'(1) << (2 * FRAC_BITS - 1);

    logic signed [SQW-1:0] xx_reg, xx_next, yy_reg, yy_next;
    logic signed [DW-1:0]  d1_reg, d1_next, d2_reg, d3_reg, d4_reg;
    logic                  pos2_reg, pos2_next, pos3_reg, pos4_reg;
    logic [AW-1:0]         a0_reg, a0_next, a1_reg, a1_next, a2_reg, a2_next;
    logic signed [CPW-1:0] c_reg, c_next;

    snx_grad_t             grad;
    logic signed [DW-1:0]  tx, ty, cxe, cye;
    logic signed [RW-1:0]  r;
    logic [RW+AW-1:0]      r_sh, r_k;
    logic [2*AW-1:0]       sq1, sq2;
    logic signed [PW-1:0]  m;

    always_comb
    begin
        grad    = snx_grad(gidx);
        cxe     = DW'(cx);
        cye     = DW'(cy);
        tx      = grad.x_en ? (grad.x_neg ? -cxe : cxe) : '0;
        ty      = grad.y_en ? (grad.y_neg ? -cye : cye) : '0;
        xx_next = SQW'(cx * cx);
        yy_next = SQW'(cy * cy);
        d1_next = tx + ty;

        // falloff term, taken to K_FRAC fractional bits
        r         = HALF - RW'(xx_reg) - RW'(yy_reg);
        pos2_next = (r > 0);
        r_sh      = {r, AW'(0)};
        r_k       = r_sh >> (2 * FRAC_BITS);
        a0_next   = r_k[AW-1:0];

        sq1     = a0_reg * a0_reg;
        a1_next = sq1[2*AW-1:AW];
        sq2     = a1_reg * a1_reg;
        a2_next = sq2[2*AW-1:AW];

        m      = $signed({1'b0, a2_reg}) * d4_reg;
        c_next = pos4_reg ? CPW'(m >>> FRAC_BITS) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en.sq)
        begin
            xx_reg <= xx_next;
            yy_reg <= yy_next;
            d1_reg <= d1_next;
        end
        if (en.rk)
        begin
            a0_reg   <= a0_next;
            pos2_reg <= pos2_next;
            d2_reg   <= d1_reg;
        end
        if (en.a1)
        begin
            a1_reg   <= a1_next;
            pos3_reg <= pos2_reg;
            d3_reg   <= d2_reg;
        end
        if (en.a2)
        begin
            a2_reg   <= a2_next;
            pos4_reg <= pos3_reg;
            d4_reg   <= d3_reg;
        end
        if (en.mul)
        begin
            c_reg <= c_next;
        end
    end

    assign contrib = c_reg;

endmodule
